// ===== hdl/xcr_pkg.sv =====
package xcr_pkg;

  // Control bytes of the transfer protocol.
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  // Input operation codes.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
  localparam logic [1:0] VERDICT_DISCARD = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd1;
  localparam logic [2:0] ERR_NUMBER     = 3'd2;
  localparam logic [2:0] ERR_CRC        = 3'd3;
  localparam logic [2:0] ERR_HEADER     = 3'd4;

  // CRC-16 generator polynomial, MSB first.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One result item as it is queued for the output channel.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [1:0] verdict;
    logic [2:0] error_code;
    logic       session_over;
    logic       last;
  } result_t;

  // Bytewise CRC-16 update, eight bit steps unrolled.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/xmodem_crc_receiver.sv =====
// Receiver side of an XMODEM-CRC transfer, fed one event per input item.
// Input channel: item_valid/item_stall with op (0 received byte, 1 receive
// timeout, 2 start new session) and rx_byte. An item is taken at a clock edge
// where item_valid is high and item_stall is low.
// Output channel: result_valid/result_stall with one result item per
// transfer: a control byte to send back, a provisional payload byte with its
// index, the packet verdict, an error code, session end and a last flag that
// marks the final result of one input item. An input item yields zero, one
// or two result items (two only when the error limit aborts with CAN twice).
// Each input item is decoded in the cycle it is taken; its results are
// written into a four-deep result queue whose head drives the output.
// Throughput is one input item per cycle while the output drains.
// item_stall rises when three or more results are queued, so a stalled
// output side holds the input back only once three results are queued.
// cfg_write loads max_errors from cfg_data; write it only while idle.
// Reset (rst, synchronous) empties the queue, sets max_errors to 10 and
// starts a fresh session expecting packet number 1.
module xmodem_crc_receiver #(
  parameter int PACKET_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  // Input items.
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  // Configuration.
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  // Result items.
  output logic       result_valid,
  input  logic       result_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic [6:0] data_index,
  output logic [1:0] verdict,
  output logic [2:0] error_code,
  output logic       session_over,
  output logic       last
);

  localparam int CNT_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(PACKET_BYTES - 1);

  // Receive phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NUMBER = 3'd1;
  localparam logic [2:0] PH_COMPL  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;

  // Session state.
  logic [7:0]       max_errors;
  logic [2:0]       phase, phase_next;
  logic [7:0]       expected_number, expected_number_next;
  logic [7:0]       received_number, received_number_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       crc_high_byte, crc_high_byte_next;
  logic [7:0]       error_count, error_count_next;
  logic             ended, ended_next;

  // Result queue.
  xcr_pkg::result_t queue [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;

  logic             accept;
  logic             pop;
  logic [1:0]       push_n;
  xcr_pkg::result_t res0, res1;

  // Decode helpers.
  logic             do_fail;
  logic [1:0]       fail_verdict;
  logic [2:0]       fail_err;
  logic [7:0]       err_inc;
  logic [15:0]      got_crc;
  logic [8:0]       number_sum;

  assign item_stall = (count >= 3'd3);
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;

  assign got_crc    = {crc_high_byte, rx_byte};
  assign number_sum = {1'b0, received_number} + {1'b0, rx_byte};
  assign err_inc    = (error_count == 8'hFF) ? error_count : error_count + 8'd1;

  // Decode one input item into next state and up to two results.
  always_comb begin
    phase_next           = phase;
    expected_number_next = expected_number;
    received_number_next = received_number;
    byte_count_next      = byte_count;
    running_crc_next     = running_crc;
    crc_high_byte_next   = crc_high_byte;
    error_count_next     = error_count;
    ended_next           = ended;
    push_n               = 2'd0;
    res0                 = '0;
    res1                 = '0;
    do_fail              = 1'b0;
    fail_verdict         = xcr_pkg::VERDICT_NONE;
    fail_err             = xcr_pkg::ERR_NONE;

    if (op == xcr_pkg::OP_RESTART) begin
      phase_next           = PH_HEADER;
      expected_number_next = 8'd1;
      received_number_next = 8'd0;
      byte_count_next      = '0;
      running_crc_next     = 16'd0;
      crc_high_byte_next   = 8'd0;
      error_count_next     = 8'd0;
      ended_next           = 1'b0;
    end else if (op == xcr_pkg::OP_TIMEOUT && !ended) begin
      if (phase != PH_HEADER) begin
        do_fail      = 1'b1;
        fail_verdict = xcr_pkg::VERDICT_DISCARD;
        fail_err     = xcr_pkg::ERR_TIMEOUT;
      end
    end else if (op == xcr_pkg::OP_BYTE && !ended) begin
      unique case (phase)
        PH_HEADER: begin
          if (rx_byte == xcr_pkg::BYTE_SOH) begin
            phase_next = PH_NUMBER;
          end else if (rx_byte == xcr_pkg::BYTE_EOT) begin
            ended_next        = 1'b1;
            push_n            = 2'd1;
            res0.tx_valid     = 1'b1;
            res0.tx_byte      = xcr_pkg::BYTE_ACK;
            res0.session_over = 1'b1;
            res0.last         = 1'b1;
          end else if (rx_byte == xcr_pkg::BYTE_CAN) begin
            ended_next        = 1'b1;
            push_n            = 2'd1;
            res0.session_over = 1'b1;
            res0.last         = 1'b1;
          end else begin
            do_fail      = 1'b1;
            fail_verdict = xcr_pkg::VERDICT_NONE;
            fail_err     = xcr_pkg::ERR_HEADER;
          end
        end
        PH_NUMBER: begin
          received_number_next = rx_byte;
          phase_next           = PH_COMPL;
        end
        PH_COMPL: begin
          if (received_number != expected_number || number_sum != 9'd255) begin
            do_fail      = 1'b1;
            fail_verdict = xcr_pkg::VERDICT_DISCARD;
            fail_err     = xcr_pkg::ERR_NUMBER;
          end else begin
            byte_count_next  = '0;
            running_crc_next = 16'd0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          running_crc_next = xcr_pkg::crc_update(running_crc, rx_byte);
          byte_count_next  = byte_count + CNT_W'(1);
          if (byte_count == LAST_INDEX) begin
            phase_next = PH_CRC_HI;
          end
          push_n          = 2'd1;
          res0.data_valid = 1'b1;
          res0.data_byte  = rx_byte;
          res0.data_index = 7'(byte_count);
          res0.last       = 1'b1;
        end
        PH_CRC_HI: begin
          crc_high_byte_next = rx_byte;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          phase_next = PH_HEADER;
          if (got_crc != running_crc) begin
            do_fail      = 1'b1;
            fail_verdict = xcr_pkg::VERDICT_DISCARD;
            fail_err     = xcr_pkg::ERR_CRC;
          end else begin
            expected_number_next = expected_number + 8'd1;
            push_n               = 2'd1;
            res0.tx_valid        = 1'b1;
            res0.tx_byte         = xcr_pkg::BYTE_ACK;
            res0.verdict         = xcr_pkg::VERDICT_COMMIT;
            res0.last            = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end

    // Error path: count the error, then NAK or abort with CAN twice.
    if (do_fail) begin
      phase_next       = PH_HEADER;
      error_count_next = err_inc;
      res0.tx_valid    = 1'b1;
      res0.verdict     = fail_verdict;
      res0.error_code  = fail_err;
      if (err_inc >= max_errors) begin
        ended_next        = 1'b1;
        push_n            = 2'd2;
        res0.tx_byte      = xcr_pkg::BYTE_CAN;
        res0.session_over = 1'b1;
        res1.tx_valid     = 1'b1;
        res1.tx_byte      = xcr_pkg::BYTE_CAN;
        res1.session_over = 1'b1;
        res1.last         = 1'b1;
      end else begin
        push_n       = 2'd1;
        res0.tx_byte = xcr_pkg::BYTE_NAK;
        res0.last    = 1'b1;
      end
    end
  end

  // Control and session registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors      <= 8'd10;
      phase           <= PH_HEADER;
      expected_number <= 8'd1;
      received_number <= 8'd0;
      byte_count      <= '0;
      running_crc     <= 16'd0;
      crc_high_byte   <= 8'd0;
      error_count     <= 8'd0;
      ended           <= 1'b0;
      wr_ptr          <= 2'd0;
      rd_ptr          <= 2'd0;
      count           <= 3'd0;
    end else begin
      if (cfg_write) begin
        max_errors <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        expected_number <= expected_number_next;
        received_number <= received_number_next;
        byte_count      <= byte_count_next;
        running_crc     <= running_crc_next;
        crc_high_byte   <= crc_high_byte_next;
        error_count     <= error_count_next;
        ended           <= ended_next;
        wr_ptr          <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_n} : 3'd0) - {2'b00, pop};
    end
  end

  // Queue storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  // Head of the queue drives the output channel.
  assign result_valid = (count != 3'd0);
  assign tx_valid     = queue[rd_ptr].tx_valid;
  assign tx_byte      = queue[rd_ptr].tx_byte;
  assign data_valid   = queue[rd_ptr].data_valid;
  assign data_byte    = queue[rd_ptr].data_byte;
  assign data_index   = queue[rd_ptr].data_index;
  assign verdict      = queue[rd_ptr].verdict;
  assign error_code   = queue[rd_ptr].error_code;
  assign session_over = queue[rd_ptr].session_over;
  assign last         = queue[rd_ptr].last;

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PACKET_LEN = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 150;
  localparam int REPORT_CAP = 200;

  typedef enum logic [2:0] {
    LINE_HEADER,
    LINE_NUMBER,
    LINE_COMPLEMENT,
    LINE_PAYLOAD,
    LINE_CRC_HIGH,
    LINE_CRC_LOW
  } line_phase_t;

  typedef enum int {
    PK_GOOD,
    PK_BAD_CRC,
    PK_TIMED_OUT,
    PK_BAD_NUMBER,
    PK_BAD_COMPLEMENT,
    PK_ABANDONED
  } packet_kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } line_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] op = xcr_pkg::OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [6:0] data_index;
  logic [1:0] verdict;
  logic [2:0] error_code;
  logic       session_over;
  logic       last;

  xmodem_crc_receiver #(.PACKET_BYTES(PACKET_LEN)) u_dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Items waiting to be sent and results the receiver must still produce.
  line_item_t       outgoing_items[$];
  xcr_pkg::result_t due_results[$];
  int               items_counted = 0;
  int               mismatches = 0;
  int               reports = 0;
  logic             calm = 1'b0;

  // Predicted receiver state.
  line_phase_t rx_phase;
  logic [7:0]  next_number;
  logic [7:0]  got_number;
  logic [7:0]  crc_high;
  logic [7:0]  err_count;
  logic [7:0]  limit_errors;
  logic [15:0] crc_acc;
  int          payload_count;
  logic        closed;

  // What the sender side believes about the session while it builds items.
  logic [7:0] sent_number;
  logic [7:0] sent_errors;
  logic       sent_closed;

  // CRC-16/XMODEM, one message bit at a time.
  function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r = {r[14:0], 1'b0} ^ (fb ? xcr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void fresh_session();
    rx_phase = LINE_HEADER;
    next_number = 8'd1;
    got_number = 8'd0;
    crc_high = 8'd0;
    err_count = 8'd0;
    crc_acc = 16'h0000;
    payload_count = 0;
    closed = 1'b0;
  endfunction

  function automatic void queue_result(input logic tx_v, input logic [7:0] tx_b,
                                       input logic d_v, input logic [7:0] d_b,
                                       input logic [6:0] d_i, input logic [1:0] vd,
                                       input logic [2:0] ec, input logic over,
                                       input logic fin);
    xcr_pkg::result_t r;
    r.tx_valid = tx_v;
    r.tx_byte = tx_b;
    r.data_valid = d_v;
    r.data_byte = d_b;
    r.data_index = d_i;
    r.verdict = vd;
    r.error_code = ec;
    r.session_over = over;
    r.last = fin;
    due_results.push_back(r);
  endfunction

  // An error sends NAK, or two CAN bytes once the error limit is reached.
  function automatic void reject_packet(input logic [1:0] vd, input logic [2:0] ec);
    rx_phase = LINE_HEADER;
    if (err_count != 8'hFF) err_count++;
    if (err_count >= limit_errors) begin
      closed = 1'b1;
      queue_result(1'b1, xcr_pkg::BYTE_CAN, 1'b0, 8'h00, 7'd0, vd, ec, 1'b1, 1'b0);
      queue_result(1'b1, xcr_pkg::BYTE_CAN, 1'b0, 8'h00, 7'd0, xcr_pkg::VERDICT_NONE,
                   xcr_pkg::ERR_NONE, 1'b1, 1'b1);
    end else begin
      queue_result(1'b1, xcr_pkg::BYTE_NAK, 1'b0, 8'h00, 7'd0, vd, ec, 1'b0, 1'b1);
    end
  endfunction

  // Advances the predicted receiver by one accepted item.
  function automatic void model_receive(input logic [1:0] o, input logic [7:0] b);
    if (o == xcr_pkg::OP_RESTART) begin
      fresh_session();
    end else if (o == xcr_pkg::OP_TIMEOUT && !closed) begin
      // A timeout only counts once a header has been seen.
      if (rx_phase != LINE_HEADER) begin
        reject_packet(xcr_pkg::VERDICT_DISCARD, xcr_pkg::ERR_TIMEOUT);
      end
    end else if (o == xcr_pkg::OP_BYTE && !closed) begin
      case (rx_phase)
        LINE_HEADER: begin
          if (b == xcr_pkg::BYTE_SOH) begin
            rx_phase = LINE_NUMBER;
          end else if (b == xcr_pkg::BYTE_EOT) begin
            closed = 1'b1;
            queue_result(1'b1, xcr_pkg::BYTE_ACK, 1'b0, 8'h00, 7'd0, xcr_pkg::VERDICT_NONE,
                         xcr_pkg::ERR_NONE, 1'b1, 1'b1);
          end else if (b == xcr_pkg::BYTE_CAN) begin
            closed = 1'b1;
            queue_result(1'b0, 8'h00, 1'b0, 8'h00, 7'd0, xcr_pkg::VERDICT_NONE,
                         xcr_pkg::ERR_NONE, 1'b1, 1'b1);
          end else begin
            reject_packet(xcr_pkg::VERDICT_NONE, xcr_pkg::ERR_HEADER);
          end
        end
        LINE_NUMBER: begin
          got_number = b;
          rx_phase = LINE_COMPLEMENT;
        end
        LINE_COMPLEMENT: begin
          if (got_number != next_number || ({1'b0, got_number} + {1'b0, b}) != 9'd255) begin
            reject_packet(xcr_pkg::VERDICT_DISCARD, xcr_pkg::ERR_NUMBER);
          end else begin
            payload_count = 0;
            crc_acc = 16'h0000;
            rx_phase = LINE_PAYLOAD;
          end
        end
        LINE_PAYLOAD: begin
          queue_result(1'b0, 8'h00, 1'b1, b, 7'(payload_count), xcr_pkg::VERDICT_NONE,
                       xcr_pkg::ERR_NONE, 1'b0, 1'b1);
          crc_acc = crc16_shift(crc_acc, b);
          payload_count++;
          if (payload_count >= PACKET_LEN) rx_phase = LINE_CRC_HIGH;
        end
        LINE_CRC_HIGH: begin
          crc_high = b;
          rx_phase = LINE_CRC_LOW;
        end
        default: begin
          rx_phase = LINE_HEADER;
          if ({crc_high, b} != crc_acc) begin
            reject_packet(xcr_pkg::VERDICT_DISCARD, xcr_pkg::ERR_CRC);
          end else begin
            next_number++;
            queue_result(1'b1, xcr_pkg::BYTE_ACK, 1'b0, 8'h00, 7'd0, xcr_pkg::VERDICT_COMMIT,
                         xcr_pkg::ERR_NONE, 1'b0, 1'b1);
          end
        end
      endcase
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (reports < REPORT_CAP) begin
        reports++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  // Sender: presents queued items, holds a stalled item steady, idles in bursts.
  line_item_t head_item;
  int         send_gap = 0;
  int         send_steady = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      op <= xcr_pkg::OP_BYTE;
      rx_byte <= 8'h00;
    end else begin
      if (item_valid && !item_stall) model_receive(op, rx_byte);
      if (!(item_valid && item_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (outgoing_items.size() != 0 && !calm && send_steady == 0 &&
                     $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 18);
          send_steady = $urandom_range(0, 40);
          item_valid <= 1'b0;
        end else if (outgoing_items.size() != 0) begin
          head_item = outgoing_items.pop_front();
          item_valid <= 1'b1;
          op <= head_item.op;
          rx_byte <= head_item.data;
          if (send_steady > 0) send_steady--;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each accepted result and stalls in bursts, once for a long stretch.
  xcr_pkg::result_t want;
  int               results_seen = 0;
  int               hold_left = 0;
  logic             hold_used = 1'b0;
  int               stall_gap = 0;
  int               recv_steady = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: result expected none, got tx %0b/%0h data %0b/%0h/%0d v %0d e %0d",
                     $time, tx_valid, tx_byte, data_valid, data_byte, data_index, verdict,
                     error_code);
          end
        end else begin
          want = due_results.pop_front();
          compare_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
          compare_field("tx_byte", want.tx_byte, tx_byte);
          compare_field("data_valid", 8'(want.data_valid), 8'(data_valid));
          compare_field("data_byte", want.data_byte, data_byte);
          compare_field("data_index", 8'(want.data_index), 8'(data_index));
          compare_field("verdict", 8'(want.verdict), 8'(verdict));
          compare_field("error_code", 8'(want.error_code), 8'(error_code));
          compare_field("session_over", 8'(want.session_over), 8'(session_over));
          compare_field("last", 8'(want.last), 8'(last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_used && !calm && results_seen >= 60 && result_valid &&
                   !result_stall && data_valid === 1'b1 && data_index < 7'd64) begin
        // Early in a packet, so the sender keeps offering payload and the block backs up.
        hold_used = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        result_stall <= 1'b1;
      end else if (!calm && recv_steady == 0 && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 18);
        recv_steady = $urandom_range(0, 40);
        result_stall <= 1'b1;
      end else begin
        if (recv_steady > 0) recv_steady--;
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] o, input logic [7:0] d, input bit counted);
    line_item_t it;
    it.op = o;
    it.data = d;
    outgoing_items.push_back(it);
    if (counted) items_counted++;
  endtask

  function automatic void note_sent_error();
    if (sent_errors != 8'hFF) sent_errors++;
    if (sent_errors >= limit_errors) sent_closed = 1'b1;
  endfunction

  task automatic restart_session();
    push_item(xcr_pkg::OP_RESTART, 8'($urandom), 1'b1);
    sent_number = 8'd1;
    sent_errors = 8'd0;
    sent_closed = 1'b0;
  endtask

  // Waits until the block has drained, then lets it settle before a register write.
  task automatic settle();
    do @(negedge clk);
    while (outgoing_items.size() != 0 || item_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_errors = v;
  endtask

  // One packet, whole or broken in the way that kind selects.
  task automatic send_packet(input packet_kind_t kind);
    logic [7:0]  body[$];
    logic [7:0]  n;
    logic [7:0]  v;
    logic [15:0] c;
    int          fill;
    int          len;
    n = sent_number;
    if (kind == PK_BAD_NUMBER) n = sent_number + 8'($urandom_range(1, 255));
    body.push_back(n);
    if (kind == PK_BAD_COMPLEMENT) body.push_back(~n ^ 8'($urandom_range(1, 255)));
    else body.push_back(~n);
    fill = $urandom_range(0, 7);
    c = 16'h0000;
    for (int i = 0; i < PACKET_LEN; i++) begin
      if (fill == 0) v = 8'h00;
      else if (fill == 1) v = 8'hFF;
      else v = 8'($urandom);
      body.push_back(v);
      c = crc16_shift(c, v);
    end
    if (kind == PK_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    case (kind)
      PK_BAD_NUMBER, PK_BAD_COMPLEMENT: len = 2;
      PK_TIMED_OUT, PK_ABANDONED: begin
        if ($urandom_range(0, 1)) len = $urandom_range(0, 6);
        else len = $urandom_range(0, body.size() - 1);
      end
      default: len = body.size();
    endcase
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_SOH, 1'b1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 49) == 0) push_item(OP_UNUSED, 8'($urandom), 1'b0);
      push_item(xcr_pkg::OP_BYTE, body[i], 1'b1);
    end
    case (kind)
      PK_GOOD: sent_number++;
      PK_TIMED_OUT: begin
        push_item(xcr_pkg::OP_TIMEOUT, 8'($urandom), 1'b1);
        note_sent_error();
      end
      PK_ABANDONED: restart_session();
      default: note_sent_error();
    endcase
  endtask

  // Line noise between packets: stray bytes, idle timeouts and unused operations.
  task automatic send_noise();
    logic [7:0] v;
    int         pick;
    repeat ($urandom_range(1, 4)) begin
      if (!sent_closed) begin
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          push_item(xcr_pkg::OP_TIMEOUT, 8'($urandom), 1'b0);
        end else if (pick == 1) begin
          push_item(OP_UNUSED, 8'($urandom), 1'b0);
        end else begin
          do v = 8'($urandom);
          while (v == xcr_pkg::BYTE_SOH || v == xcr_pkg::BYTE_EOT || v == xcr_pkg::BYTE_CAN);
          push_item(xcr_pkg::OP_BYTE, v, 1'b1);
          note_sent_error();
        end
      end
    end
  endtask

  // Mostly packets with random content, the rest broken packets, noise and session ends.
  task automatic run_random(input int target, input bit lead_good);
    int stop_at;
    int pick;
    sent_number = next_number;
    sent_errors = err_count;
    sent_closed = closed;
    stop_at = items_counted + target;
    if (lead_good) begin
      if (sent_closed) restart_session();
      send_packet(PK_GOOD);
    end
    while (items_counted < stop_at) begin
      if (sent_closed) begin
        // Items after the end of a session are dropped until a restart.
        if ($urandom_range(0, 1)) begin
          push_item(xcr_pkg::OP_BYTE, 8'($urandom), 1'b0);
          push_item(xcr_pkg::OP_TIMEOUT, 8'($urandom), 1'b0);
        end
        restart_session();
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) send_packet(PK_GOOD);
      else if (pick < 40) send_packet(PK_BAD_CRC);
      else if (pick < 55) send_packet(PK_TIMED_OUT);
      else if (pick < 63) send_packet(PK_BAD_NUMBER);
      else if (pick < 70) send_packet(PK_BAD_COMPLEMENT);
      else if (pick < 74) send_packet(PK_ABANDONED);
      else if (pick < 88) send_noise();
      else if (pick < 94) begin
        push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_EOT, 1'b1);
        sent_closed = 1'b1;
      end else begin
        push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_CAN, 1'b1);
        sent_closed = 1'b1;
      end
    end
  endtask

  initial begin
    fresh_session();
    limit_errors = 8'd10;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Directed part with an error limit of two.
    write_limit(8'd2);
    push_item(xcr_pkg::OP_RESTART, 8'h00, 1'b1);
    push_item(OP_UNUSED, 8'hFF, 1'b0);
    push_item(xcr_pkg::OP_TIMEOUT, 8'h00, 1'b0);
    push_item(xcr_pkg::OP_BYTE, 8'h02, 1'b1);
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_SOH, 1'b1);
    push_item(xcr_pkg::OP_TIMEOUT, 8'hA5, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'h00, 1'b0);
    push_item(xcr_pkg::OP_TIMEOUT, 8'h00, 1'b0);
    push_item(xcr_pkg::OP_RESTART, 8'hFF, 1'b1);
    // Complement that sums to 256 instead of 255, then a wrong packet number.
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_SOH, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'h01, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'hFF, 1'b1);
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_SOH, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'h02, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'hFD, 1'b1);
    push_item(xcr_pkg::OP_RESTART, 8'h00, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'hFF, 1'b1);
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_EOT, 1'b1);
    push_item(xcr_pkg::OP_RESTART, 8'h00, 1'b1);
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_CAN, 1'b1);
    push_item(xcr_pkg::OP_RESTART, 8'h00, 1'b1);
    // A timeout after the first payload byte.
    push_item(xcr_pkg::OP_BYTE, xcr_pkg::BYTE_SOH, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'h01, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'hFE, 1'b1);
    push_item(xcr_pkg::OP_BYTE, 8'h5A, 1'b1);
    push_item(xcr_pkg::OP_TIMEOUT, 8'h00, 1'b1);
    settle();

    // A limit of zero aborts on the first error.
    write_limit(8'd0);
    push_item(xcr_pkg::OP_BYTE, 8'h80, 1'b1);
    push_item(xcr_pkg::OP_RESTART, 8'h00, 1'b1);
    settle();

    // Random part; the session carries over between limit changes.
    write_limit(8'd255);
    run_random(100, 1'b1);
    settle();
    write_limit(8'd1);
    run_random(100, 1'b0);
    settle();
    write_limit(8'($urandom_range(2, 12)));
    run_random(100, 1'b1);
    settle();
    @(posedge clk);
    calm <= 1'b1;
    write_limit(8'($urandom_range(1, 255)));
    run_random(100, 1'b0);
    settle();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
